@@ design/vic_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types and constants for the vectored interrupt controller.
// ----------------------------------------------------------------------------
package vic_pkg;

    // Operation codes carried on the slave-side tuser
    typedef enum logic [2:0] {
        OP_RD_EN   = 3'd0,
        OP_RD_PEND = 3'd1,
        OP_WR_EN   = 3'd2,
        OP_WR_PEND = 3'd3,
        OP_RAISE   = 3'd4,
        OP_MASTER  = 3'd5,
        OP_TICK    = 3'd6,
        OP_SERVICE = 3'd7
    } t_op;

    // Vector address = base + step * source
    localparam logic [6:0] VEC_BASE = 7'h40;
    localparam int         VEC_SHIFT = 3;

    // One operation word
    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [2:0] source;
    } t_item;

    // One result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       wake;
        logic       take_vector;
        logic [6:0] vector;
        logic       master_on;
    } t_result;

endpackage

@@ design/vic_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vic_core
// Architectural state (enable, pending, master enable, enable delay) and the
// combinational execute logic for one operation word.
// ----------------------------------------------------------------------------
module vic_core
    import vic_pkg::*;
#(
    parameter int NUM_SOURCES = 5
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,     // execute i_item this cycle and commit state
    input  t_item   i_item,
    output t_result o_result
);

    // Enable delay codes
    localparam logic [1:0] DLY_IDLE = 2'd0;
    localparam logic [1:0] DLY_LAST = 2'd1;
    localparam logic [1:0] DLY_WAIT = 2'd2;

    // Sources that take part in arbitration
    localparam logic [7:0] SRC_MASK = 8'((9'd1 << NUM_SOURCES) - 9'd1);

    logic [7:0] r_enable;
    logic [7:0] r_pending;
    logic       r_master;
    logic [1:0] r_delay;

    logic [7:0] n_enable;
    logic [7:0] n_pending;
    logic       n_master;
    logic [1:0] n_delay;

    logic [7:0] cand;
    logic       found;
    logic [2:0] win_idx;
    logic       raise_ok;

    // Fixed-priority pick: lowest index wins
    always_comb begin
        cand    = r_enable & r_pending & SRC_MASK;
        found   = 1'b0;
        win_idx = '0;
        for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
            if (cand[i]) begin
                found   = 1'b1;
                win_idx = 3'(i);
            end
        end
    end

    assign raise_ok = ({1'b0, i_item.source} < 4'(NUM_SOURCES));

    // Execute one operation
    always_comb begin
        n_enable  = r_enable;
        n_pending = r_pending;
        n_master  = r_master;
        n_delay   = r_delay;
        o_result  = '0;
        unique case (i_item.op)
            OP_RD_EN:   o_result.read_data = r_enable;
            OP_RD_PEND: o_result.read_data = r_pending;
            OP_WR_EN:   n_enable  = i_item.data;
            OP_WR_PEND: n_pending = i_item.data;
            OP_RAISE: begin
                if (raise_ok) begin
                    n_pending = r_pending | (8'd1 << i_item.source);
                end
            end
            OP_MASTER: begin
                if (i_item.data[0]) begin
                    if (!r_master) begin
                        n_delay = DLY_WAIT;
                    end
                end else begin
                    n_master = 1'b0;
                    n_delay  = DLY_IDLE;
                end
            end
            OP_TICK: begin
                if (r_delay == DLY_LAST) begin
                    n_master = 1'b1;
                    n_delay  = DLY_IDLE;
                end else if (r_delay != DLY_IDLE) begin
                    n_delay = DLY_LAST;
                end
            end
            default: begin
                // service check
                if (found) begin
                    o_result.wake = 1'b1;
                    if (r_master) begin
                        n_master             = 1'b0;
                        n_pending            = r_pending & ~(8'd1 << win_idx);
                        o_result.take_vector = 1'b1;
                        o_result.vector      = VEC_BASE + 7'({win_idx, 3'b000});
                    end
                end
            end
        endcase
        o_result.master_on = n_master;
    end

    // State registers, committed only when the word executes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= '0;
            r_pending <= '0;
            r_master  <= 1'b0;
            r_delay   <= DLY_IDLE;
        end else if (i_fire) begin
            r_enable  <= n_enable;
            r_pending <= n_pending;
            r_master  <= n_master;
            r_delay   <= n_delay;
        end
    end

    // An accepted interrupt always drops the master enable
    a_take_clears_master: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.take_vector) |=> !r_master)
        else $error("master enable still set after taking a vector");

    // Master enable only turns on through a tick
    a_master_rise_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_master) |-> $past(i_fire && i_item.op == OP_TICK))
        else $error("master enable rose without a tick");

    // Disable request clears master and cancels a scheduled enable
    a_disable_cancels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_item.op == OP_MASTER && !i_item.data[0])
            |=> (!r_master && r_delay == DLY_IDLE))
        else $error("disable did not cancel enable");

    // Unused delay code never appears
    a_delay_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delay != 2'd3)
        else $error("enable delay reached unused code");

    // A taken vector is in range of the configured sources
    a_vector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.take_vector)
            |-> (o_result.wake && ({1'b0, win_idx} < 4'(NUM_SOURCES))))
        else $error("vector for a source outside the configured range");

endmodule

@@ design/vectored_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vectored_interrupt_controller
// Five-source fixed-priority vectored interrupt controller with delayed
// master enable. An accepted word waits in the input register, executes when
// the result register is free or draining, and its result word is held in
// the result register. Throughput: one word per cycle; a master stall holds
// the word in the input register and drops o_s_tready in the same cycle.
// Reset (i_rst_n low, synchronous) clears all masks, master enable and delay.
// ----------------------------------------------------------------------------
module vectored_interrupt_controller
    import vic_pkg::*;
#(
    parameter int NUM_SOURCES = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] data, [10:8] source, [15:11] zero
    input  logic [2:0]  i_s_tuser,   // [2:0] op
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // [7:0] read_data, [8] wake, [9] take_vector,
                                     // [16:10] vector, [17] master_on, [23:18] zero
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    logic    exec_fire;
    t_result exec_res;

    // Execute when a word is held and the result slot is free or draining
    assign exec_fire  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || exec_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_item.op     <= t_op'(i_s_tuser);
            r_in_item.data   <= i_s_tdata[7:0];
            r_in_item.source <= i_s_tdata[10:8];
        end
    end

    vic_core #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (exec_fire),
        .i_item   (r_in_item),
        .o_result (exec_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_out <= exec_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out.master_on, r_out.vector, r_out.take_vector,
                         r_out.wake, r_out.read_data};

endmodule

@@ dv/tb_vectored_interrupt_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vectored_interrupt_controller
// Self-checking bench for the vectored interrupt controller. Operation words
// go in on the slave stream; a scoreboard keeps its own copy of the enable,
// pending, master enable and enable countdown, predicts one result word per
// accepted operation and compares it with each word leaving the master
// stream. A directed opening is followed by random service sequences and
// lone random operations, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_vectored_interrupt_controller;
    import vic_pkg::*;

    localparam int N_SRC          = 5;
    localparam int ITEMS_TOTAL    = 1300;
    localparam int N_PHASES       = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Countdown of a scheduled master enable
    typedef enum bit [1:0] {
        ARM_IDLE = 2'd0,
        ARM_LAST = 2'd1,
        ARM_WAIT = 2'd2
    } t_arm;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks controller state, queues expected result words
    // ------------------------------------------------------------------------
    class vic_scoreboard;
        logic [7:0] en_reg;
        logic [7:0] pend_reg;
        bit         master_en;
        t_arm       arm;
        t_result    expected_q[$];
        int         checked;
        int         mismatches;
        int         vectors_taken;
        int         wakes_only;

        function void clear();
            en_reg    = '0;
            pend_reg  = '0;
            master_en = 1'b0;
            arm       = ARM_IDLE;
            expected_q.delete();
        endfunction

        // Apply one accepted operation and queue the word it must produce
        function void note_op(t_item it);
            t_result r;
            r = '0;
            case (it.op)
                OP_RD_EN:   r.read_data = en_reg;
                OP_RD_PEND: r.read_data = pend_reg;
                OP_WR_EN:   en_reg = it.data;
                OP_WR_PEND: pend_reg = it.data;
                OP_RAISE: begin
                    if (it.source < N_SRC) pend_reg[it.source] = 1'b1;
                end
                OP_MASTER: begin
                    if (it.data[0]) begin
                        // request while off (re)starts the countdown
                        if (!master_en) arm = ARM_WAIT;
                    end else begin
                        master_en = 1'b0;
                        arm       = ARM_IDLE;
                    end
                end
                OP_TICK: begin
                    if (arm == ARM_LAST) begin
                        master_en = 1'b1;
                        arm       = ARM_IDLE;
                    end else if (arm != ARM_IDLE) begin
                        arm = ARM_LAST;
                    end
                end
                OP_SERVICE: begin
                    // fixed priority: lowest enabled pending source wins
                    for (int i = 0; i < N_SRC; i++) begin
                        if (en_reg[i] && pend_reg[i]) begin
                            r.wake = 1'b1;
                            if (master_en) begin
                                master_en     = 1'b0;
                                pend_reg[i]   = 1'b0;
                                r.take_vector = 1'b1;
                                r.vector      = VEC_BASE + 7'(i << VEC_SHIFT);
                                vectors_taken++;
                            end else begin
                                wakes_only++;
                            end
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.master_on = master_en;
            expected_q.push_back(r);
        endfunction

        // Compare one result word against the oldest expectation
        function void check_word(logic [23:0] word);
            t_result got, want;
            got.read_data   = word[7:0];
            got.wake        = word[8];
            got.take_vector = word[9];
            got.vector      = word[16:10];
            got.master_on   = word[17];
            checked++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word %0d arrived with nothing expected: %06h",
                             $realtime, checked, word);
            end else begin
                want = expected_q.pop_front();
                if (got.read_data !== want.read_data || got.wake !== want.wake ||
                    got.take_vector !== want.take_vector || got.vector !== want.vector ||
                    got.master_on !== want.master_on) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: word %0d exp rd=%02h wake=%0b take=%0b vec=%02h ",
                                  "mst=%0b / got rd=%02h wake=%0b take=%0b vec=%02h mst=%0b"},
                                 $realtime, checked, want.read_data, want.wake,
                                 want.take_vector, want.vector, want.master_on,
                                 got.read_data, got.wake, got.take_vector, got.vector,
                                 got.master_on);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [7:0] data, [10:8] source, [15:11] zero
    logic [2:0]  i_s_tuser;   // [2:0] op
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;   // [7:0] read_data, [8] wake, [9] take_vector,
                              // [16:10] vector, [17] master_on, [23:18] zero

    vic_scoreboard sb;
    int src_idle_pct;
    int sink_stall_pct;
    int stall_left;
    int quiet_cycles;
    int items_sent;

    vectored_interrupt_controller #(
        .NUM_SOURCES (N_SRC)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap or stall length: mostly short, now and then long
    function automatic int pick_len();
        if ($urandom_range(9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Receiver: random stalls on the master side
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(99) < sink_stall_pct) begin
            i_m_tready <= 1'b0;
            stall_left = pick_len() - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Monitor: note accepted ops, check result words, watch for a hang
    always @(posedge i_clk) begin : monitor
        bit    moved;
        t_item it;
        moved = 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            it.op     = t_op'(i_s_tuser);
            it.data   = i_s_tdata[7:0];
            it.source = i_s_tdata[10:8];
            sb.note_op(it);
            moved = 1'b1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_word(o_m_tdata);
            moved = 1'b1;
        end
        if (moved || !i_rst_n) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d words outstanding",
                     quiet_cycles, sb.expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    // Present one operation word and hold it until accepted
    task automatic send_word(t_op op, logic [7:0] data, logic [2:0] src);
        int gap;
        gap = ($urandom_range(99) < src_idle_pct) ? pick_len() : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, src, data};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        if (!(op == OP_RAISE && src >= N_SRC)) items_sent++;
    endtask

    // Typical flow: raise sources, arm the master enable, tick, service.
    // Some runs are broken on purpose (early service, cancel, one tick).
    task automatic service_sequence();
        int n_raise;
        n_raise = $urandom_range(0, 3);
        if ($urandom_range(3) == 0)
            send_word(OP_WR_EN, $urandom_range(1) ? 8'hFF : 8'($urandom), 3'($urandom));
        for (int k = 0; k < n_raise; k++)
            send_word(OP_RAISE, 8'($urandom), 3'($urandom_range(N_SRC - 1)));
        if ($urandom_range(7) == 0)
            send_word(OP_WR_PEND, 8'($urandom), 3'($urandom));
        send_word(OP_MASTER, {7'($urandom), 1'b1}, 3'($urandom));
        case ($urandom_range(7))
            0: send_word(OP_MASTER, {7'($urandom), 1'b0}, 3'($urandom));
            1: send_word(OP_SERVICE, 8'($urandom), 3'($urandom));
            2: send_word(OP_RD_PEND, 8'($urandom), 3'($urandom));
            3: send_word(OP_MASTER, {7'($urandom), 1'b1}, 3'($urandom));
            default: ;
        endcase
        send_word(OP_TICK, 8'($urandom), 3'($urandom));
        if ($urandom_range(7) != 0) send_word(OP_TICK, 8'($urandom), 3'($urandom));
        send_word(OP_SERVICE, 8'($urandom), 3'($urandom));
        if ($urandom_range(3) == 0) send_word(OP_SERVICE, 8'($urandom), 3'($urandom));
        if ($urandom_range(3) == 0) send_word(OP_RD_PEND, 8'($urandom), 3'($urandom));
    endtask

    // Stimulus and end of run
    initial begin
        int phase_goal;
        sb = new();
        sb.clear();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        stall_left     = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= OP_RD_EN;
        i_m_tready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: reset values, priority, master enable timing
        send_word(OP_RD_EN, 8'h00, 3'd0);
        send_word(OP_RD_PEND, 8'h00, 3'd0);
        send_word(OP_WR_EN, 8'hFF, 3'd0);
        for (int s = 0; s < N_SRC; s++) send_word(OP_RAISE, 8'h00, 3'(s));
        send_word(OP_RAISE, 8'hFF, 3'd7);                // out of range, ignored
        send_word(OP_RD_PEND, 8'h00, 3'd0);
        send_word(OP_SERVICE, 8'h00, 3'd0);              // wake only, master off
        send_word(OP_MASTER, 8'h01, 3'd0);               // enable while off
        send_word(OP_TICK, 8'h00, 3'd0);
        send_word(OP_TICK, 8'h00, 3'd0);                 // master turns on
        send_word(OP_MASTER, 8'hFF, 3'd0);               // enable while on
        send_word(OP_SERVICE, 8'h00, 3'd0);              // takes source 0
        send_word(OP_MASTER, 8'h01, 3'd0);
        send_word(OP_MASTER, 8'h01, 3'd0);               // restart countdown
        send_word(OP_TICK, 8'h00, 3'd0);
        send_word(OP_MASTER, 8'hFE, 3'd0);               // disable cancels it
        send_word(OP_TICK, 8'h00, 3'd0);
        send_word(OP_TICK, 8'h00, 3'd0);                 // tick while idle
        send_word(OP_WR_PEND, 8'hE0, 3'd0);              // only unused bits set
        send_word(OP_SERVICE, 8'h00, 3'd0);              // no candidate

        // Random part, idling pattern changes per phase
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 25; sink_stall_pct = 25; end
                2: begin src_idle_pct = 60; sink_stall_pct = 10; end
                default: begin src_idle_pct = 10; sink_stall_pct = 60; end
            endcase
            phase_goal = items_sent + ITEMS_TOTAL / N_PHASES;
            while (items_sent < phase_goal) begin
                if ($urandom_range(9) < 7)
                    service_sequence();
                else
                    send_word(t_op'($urandom_range(7)), 8'($urandom), 3'($urandom));
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for the pipeline latency
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d operations, %0d result words checked", items_sent, sb.checked);
        $display("vectors taken: %0d, wakes with master off: %0d, mismatches: %0d",
                 sb.vectors_taken, sb.wakes_only, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
